// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition holds on every cycle out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/rltm_pkg.sv =====
// ----------------------------------------------------------------------------
// rltm_pkg
// widths, codes and fixed-point constants of the loop timing monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rltm_pkg;

    // time base and fixed point
    localparam int TIME_BITS = 48;
    localparam int FRAC_BITS = 8;

    // field widths
    localparam int CMD_W    = 2;
    localparam int TARGET_W = 17;
    localparam int WIN_W    = 8;
    localparam int OFFS_W   = 15;
    localparam int PERIOD_W = 20;
    localparam int RATE_W   = 18;
    localparam int LOAD_W   = 15;
    localparam int LAT_W    = 18;
    localparam int JIT_W    = 18;
    localparam int MISS_W   = 32;
    localparam int ACT_W    = 40;
    localparam int BUDGET_W = 28;
    localparam int CNT_W    = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOP_START = 2'd0,
        CMD_LOOP_END   = 2'd1,
        CMD_TX_START   = 2'd2,
        CMD_TX_DONE    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_PERIOD = 3'd0,
        REG_WINDOW        = 3'd1,
        REG_LOAD_OFFSET   = 3'd2,
        REG_MIN_PERIOD    = 3'd3,
        REG_MAX_PERIOD    = 3'd4,
        REG_MAX_LATENCY   = 3'd5
    } cfg_idx_t;

    // register reset values
    localparam int unsigned TARGET_RST = 10000;
    localparam int unsigned WIN_RST    = 50;
    localparam int unsigned OFFS_RST   = (9 << FRAC_BITS) / 2;
    localparam int unsigned MINP_RST   = 1000;
    localparam int unsigned MAXP_RST   = 100000;
    localparam int unsigned MAXLAT_RST = 100000;

    // estimator reset values
    localparam int unsigned RATE_RST = 100 << FRAC_BITS;
    localparam int unsigned LOAD_RST = 5 << FRAC_BITS;
    localparam int unsigned LAT_RST  = ((12 << FRAC_BITS) + 5) / 10;
    localparam int unsigned JIT_RST  = ((2 << FRAC_BITS) + 5) / 10;

    // limits
    localparam longint unsigned RATE_NUM = 64'd1000000 << FRAC_BITS;
    localparam int unsigned RATE_CAP  = 1000 << FRAC_BITS;
    localparam int unsigned LOAD_CAP  = ((999 << FRAC_BITS) + 5) / 10;
    localparam int unsigned PCT_SCALE = 100;
    localparam int          PCT_W     = 7;
    localparam int unsigned LAT_SCALE = 1000;
    localparam int unsigned LAT_ROUND = LAT_SCALE / 2;

    // smoothing weights as integer ratios
    localparam int unsigned RATE_KEEP  = 19;
    localparam int unsigned RATE_DEN   = 20;
    localparam int unsigned LOAD_KEEP  = 7;
    localparam int unsigned LOAD_GAIN  = 3;
    localparam int unsigned LOAD_DEN   = 10;
    localparam int unsigned LAT_KEEP   = 17;
    localparam int unsigned LAT_GAIN   = 3;
    localparam int unsigned LAT_DEN    = 20;
    localparam int unsigned JIT_KEEP   = 7;
    localparam int          JIT_SHIFT  = 3;
    localparam int unsigned JIT_ROUND  = (1 << JIT_SHIFT) / 2;

    // shared divider geometry
    localparam int DIV_W      = ACT_W + PCT_W + FRAC_BITS;
    localparam int DVS_W      = BUDGET_W;
    localparam int DCNT_W     = $clog2(DIV_W + 1);
    localparam int K_RATE_NUM = 28;
    localparam int K_LAT_NUM  = PERIOD_W + FRAC_BITS + 1;
    localparam int K_EMA      = 23;
    localparam int K_LOAD_EMA = 19;

endpackage

// ===== rtl/rltm_channels.sv =====
// ----------------------------------------------------------------------------
// rltm_channels
// valid/ready channel interfaces for events, results and register writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rltm_event_if;
    import rltm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [TIME_BITS-1:0] timestamp_us;

    modport source (output valid, output command, output timestamp_us, input ready);
    modport sink   (input valid, input command, input timestamp_us, output ready);
endinterface

interface rltm_result_if;
    import rltm_pkg::*;

    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] control_rate_q8;
    logic [LOAD_W-1:0] cpu_load_q8;
    logic [LAT_W-1:0]  latency_q8;
    logic [JIT_W-1:0]  jitter_q8;
    logic [MISS_W-1:0] missed_deadlines;
    logic              deadline_missed_now;

    modport source (
        output valid, output control_rate_q8, output cpu_load_q8, output latency_q8,
        output jitter_q8, output missed_deadlines, output deadline_missed_now,
        input  ready
    );
    modport sink (
        input  valid, input control_rate_q8, input cpu_load_q8, input latency_q8,
        input  jitter_q8, input missed_deadlines, input deadline_missed_now,
        output ready
    );
endinterface

interface rltm_cfg_if;
    import rltm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/realtime_loop_timing_monitor_core.sv =====
// ----------------------------------------------------------------------------
// realtime_loop_timing_monitor_core
// loop rate, cpu load, deadline, link latency and jitter monitor
// ----------------------------------------------------------------------------
// The block takes one timestamped event request at a time (loop start, loop
// end, tx start, tx done) and returns one result request per event holding the
// smoothed control rate, cpu load, latency, jitter, the saturating missed
// deadline count and a flag for a deadline missed by this very loop end. The
// four estimates are Q8 fixed point. Every quotient (instantaneous rate, load
// ratio, latency conversion and the smoothing divides) goes through one shared
// radix-2 restoring divider that yields one quotient bit per cycle, so the
// divider sets the cost: a tx start, a loop end inside a window or an event
// that updates nothing needs no divide; a loop start with a period inside the
// window runs a rate divide then a smoothing divide, a valid tx done a latency
// divide then a smoothing divide, and a loop end that closes a load window a
// 55-bit ratio divide then a 19-bit smoothing divide. A finished result
// sits in an output register, so a new event is accepted while the previous
// result still waits for its consumer. Register writes are taken at any time
// but are meant to happen only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module realtime_loop_timing_monitor_core (
    input  logic  clk,
    input  logic  rst_n,
    rltm_event_if.sink    events,
    rltm_result_if.source results,
    rltm_cfg_if.sink      cfg
);
    import rltm_pkg::*;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PREP   = 7'b0000010,
        S_EVAL   = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_POST   = 7'b0010000,
        S_MAC    = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    // what the divider is currently working on
    typedef enum logic [2:0] {
        OP_RATE_INST  = 3'd0,
        OP_RATE_EMA   = 3'd1,
        OP_LOAD_RATIO = 3'd2,
        OP_LOAD_EMA   = 3'd3,
        OP_LAT_INST   = 3'd4,
        OP_LAT_EMA    = 3'd5
    } op_t;

    localparam int PROD_W = ACT_W + PCT_W;

    // sequencer
    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    cmd_t   cmd_reg, cmd_next;

    // per-request working registers
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] diff_reg, diff_next;
    logic                 miss_reg, miss_next;
    logic [RATE_W-1:0]    t_reg, t_next;
    logic [LAT_W-1:0]     delta_reg, delta_next;

    // shared divider
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  divisor_reg, divisor_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;

    // configuration registers
    logic [TARGET_W-1:0] target_reg, target_next;
    logic [WIN_W-1:0]    window_reg, window_next;
    logic [OFFS_W-1:0]   offset_reg, offset_next;
    logic [PERIOD_W-1:0] min_period_reg, min_period_next;
    logic [PERIOD_W-1:0] max_period_reg, max_period_next;
    logic [PERIOD_W-1:0] max_lat_reg, max_lat_next;

    // monitor state
    logic [TIME_BITS-1:0] loop_start_reg, loop_start_next;
    logic [TIME_BITS-1:0] prev_start_reg, prev_start_next;
    logic [TIME_BITS-1:0] tx_start_reg, tx_start_next;
    logic [RATE_W-1:0]    rate_reg, rate_next;
    logic [LOAD_W-1:0]    load_reg, load_next;
    logic [LAT_W-1:0]     lat_reg, lat_next;
    logic [LAT_W-1:0]     prev_lat_reg, prev_lat_next;
    logic [JIT_W-1:0]     jitter_reg, jitter_next;
    logic [MISS_W-1:0]    missed_reg, missed_next;
    logic [ACT_W-1:0]     active_reg, active_next;
    logic [BUDGET_W-1:0]  budget_reg, budget_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [RATE_W-1:0] out_rate_reg, out_rate_next;
    logic [LOAD_W-1:0] out_load_reg, out_load_next;
    logic [LAT_W-1:0]  out_lat_reg, out_lat_next;
    logic [JIT_W-1:0]  out_jit_reg, out_jit_next;
    logic [MISS_W-1:0] out_missed_reg, out_missed_next;
    logic              out_miss_reg, out_miss_next;

    // datapath
    logic [TIME_BITS-1:0]  time_base;
    logic [PERIOD_W-1:0]   period;
    logic                  period_ok;
    logic                  latency_ok;
    logic                  over_budget;
    logic [K_RATE_NUM-1:0] rate_num;
    logic [K_LAT_NUM-1:0]  lat_num;
    logic [TIME_BITS:0]    act_sum;
    logic                  act_sat;
    logic [CNT_W:0]        cnt_inc;
    logic                  window_hit;
    logic [PROD_W-1:0]     pct_prod;
    logic [K_EMA-1:0]      rate_ema_num;
    logic [K_LOAD_EMA-1:0] load_ema_num;
    logic [K_EMA-1:0]      lat_ema_num;
    logic [JIT_W+3:0]      jit_acc;
    logic [RATE_W-1:0]     rate_inst;
    logic [LOAD_W-1:0]     load_ratio;
    logic [LOAD_W:0]       load_sum;
    logic [LOAD_W-1:0]     load_level;
    logic [LAT_W-1:0]      lat_inst;
    logic [LAT_W-1:0]      lat_delta;
    logic [DVS_W:0]        div_trial;
    logic [DVS_W:0]        div_sub;
    logic                  div_ge;

    // divider launch request from the sequencer
    logic              div_go;
    logic [DVS_W-1:0]  div_divisor;
    logic [DIV_W-1:0]  div_init;
    logic [DCNT_W-1:0] div_k;
    op_t               div_op;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign events.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;

    assign results.valid               = out_valid_reg;
    assign results.control_rate_q8     = out_rate_reg;
    assign results.cpu_load_q8         = out_load_reg;
    assign results.latency_q8          = out_lat_reg;
    assign results.jitter_q8           = out_jit_reg;
    assign results.missed_deadlines    = out_missed_reg;
    assign results.deadline_missed_now = out_miss_reg;

    // ------------------------------------------------------------------
    // time difference: each event measures against its own reference
    // ------------------------------------------------------------------
    always_comb
    begin
        case (cmd_reg)
            CMD_LOOP_START: time_base = prev_start_reg;
            CMD_LOOP_END:   time_base = loop_start_reg;
            default:        time_base = tx_start_reg;
        endcase
    end

    // period and latency windows are exclusive; a zero difference never counts
    assign period     = diff_reg[PERIOD_W-1:0];
    assign period_ok  = (prev_start_reg != '0)
                        && (diff_reg > TIME_BITS'(min_period_reg))
                        && (diff_reg < TIME_BITS'(max_period_reg))
                        && (diff_reg != '0);
    assign latency_ok = (diff_reg != '0) && (diff_reg < TIME_BITS'(max_lat_reg));

    // rounded dividends for rate (1e6 / p) and latency (us to ms)
    assign rate_num = K_RATE_NUM'(RATE_NUM) + K_RATE_NUM'(period >> 1);
    assign lat_num  = (K_LAT_NUM'(period) << FRAC_BITS) + K_LAT_NUM'(LAT_ROUND);

    // loop end bookkeeping
    assign over_budget = diff_reg > TIME_BITS'(target_reg);
    assign act_sum     = {1'b0, diff_reg} + (TIME_BITS + 1)'(active_reg);
    assign act_sat     = |act_sum[TIME_BITS:ACT_W];
    assign cnt_inc     = (CNT_W + 1)'(count_reg) + (CNT_W + 1)'(1);
    assign window_hit  = cnt_inc >= (CNT_W + 1)'(window_reg);

    // load ratio dividend: active * 100 in Q8
    assign pct_prod = PROD_W'(active_reg) * PROD_W'(PCT_SCALE);

    // smoothing dividends, rounded half up by the added half divisor
    assign rate_ema_num = K_EMA'(rate_reg) * K_EMA'(RATE_KEEP) + K_EMA'(t_reg)
                          + K_EMA'(RATE_DEN / 2);
    assign load_ema_num = K_LOAD_EMA'(load_reg) * K_LOAD_EMA'(LOAD_KEEP)
                          + K_LOAD_EMA'(t_reg[LOAD_W-1:0]) * K_LOAD_EMA'(LOAD_GAIN)
                          + K_LOAD_EMA'(LOAD_DEN / 2);
    assign lat_ema_num  = K_EMA'(lat_reg) * K_EMA'(LAT_KEEP)
                          + K_EMA'(t_reg) * K_EMA'(LAT_GAIN) + K_EMA'(LAT_DEN / 2);
    assign jit_acc      = (JIT_W + 4)'(jitter_reg) * (JIT_W + 4)'(JIT_KEEP)
                          + (JIT_W + 4)'(delta_reg) + (JIT_W + 4)'(JIT_ROUND);

    // quotient post-processing
    assign rate_inst  = (quo_reg > DIV_W'(RATE_CAP)) ? RATE_W'(RATE_CAP)
                                                     : quo_reg[RATE_W-1:0];
    assign load_ratio = (quo_reg > DIV_W'(LOAD_CAP)) ? LOAD_W'(LOAD_CAP)
                                                     : quo_reg[LOAD_W-1:0];
    assign load_sum   = (LOAD_W + 1)'(load_ratio) + (LOAD_W + 1)'(offset_reg);
    assign load_level = (load_sum > (LOAD_W + 1)'(LOAD_CAP)) ? LOAD_W'(LOAD_CAP)
                                                             : load_sum[LOAD_W-1:0];
    assign lat_inst   = quo_reg[LAT_W-1:0];
    assign lat_delta  = (lat_inst > prev_lat_reg) ? (lat_inst - prev_lat_reg)
                                                  : (prev_lat_reg - lat_inst);

    // one restoring step: shift in the next dividend bit, try a subtract
    assign div_trial = {rem_reg, quo_reg[DIV_W-1]};
    assign div_sub   = div_trial - {1'b0, divisor_reg};
    assign div_ge    = div_trial >= {1'b0, divisor_reg};

    // ------------------------------------------------------------------
    // sequencer and state update
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        cmd_next        = cmd_reg;
        now_next        = now_reg;
        diff_next       = diff_reg;
        miss_next       = miss_reg;
        t_next          = t_reg;
        delta_next      = delta_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        target_next     = target_reg;
        window_next     = window_reg;
        offset_next     = offset_reg;
        min_period_next = min_period_reg;
        max_period_next = max_period_reg;
        max_lat_next    = max_lat_reg;
        loop_start_next = loop_start_reg;
        prev_start_next = prev_start_reg;
        tx_start_next   = tx_start_reg;
        rate_next       = rate_reg;
        load_next       = load_reg;
        lat_next        = lat_reg;
        prev_lat_next   = prev_lat_reg;
        jitter_next     = jitter_reg;
        missed_next     = missed_reg;
        active_next     = active_reg;
        budget_next     = budget_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_rate_next   = out_rate_reg;
        out_load_next   = out_load_reg;
        out_lat_next    = out_lat_reg;
        out_jit_next    = out_jit_reg;
        out_missed_next = out_missed_reg;
        out_miss_next   = out_miss_reg;

        div_go      = 1'b0;
        div_divisor = '0;
        div_init    = '0;
        div_k       = '0;
        div_op      = op_reg;

        // register writes; truncated to the register width
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_TARGET_PERIOD: target_next     = cfg.data[TARGET_W-1:0];
                REG_WINDOW:        window_next     = cfg.data[WIN_W-1:0];
                REG_LOAD_OFFSET:   offset_next     = cfg.data[OFFS_W-1:0];
                REG_MIN_PERIOD:    min_period_next = cfg.data[PERIOD_W-1:0];
                REG_MAX_PERIOD:    max_period_next = cfg.data[PERIOD_W-1:0];
                REG_MAX_LATENCY:   max_lat_next    = cfg.data[PERIOD_W-1:0];
                default:           ;
            endcase
        end

        // result taken by the consumer
        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (events.valid)
                begin
                    cmd_next   = cmd_t'(events.command);
                    now_next   = events.timestamp_us;
                    miss_next  = 1'b0;
                    state_next = S_PREP;
                end
            end

            S_PREP:
            begin
                diff_next  = now_reg - time_base;
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                state_next = S_FINISH;
                case (cmd_reg)
                    CMD_LOOP_START:
                    begin
                        loop_start_next = now_reg;
                        prev_start_next = now_reg;
                        if (period_ok)
                        begin
                            div_go      = 1'b1;
                            div_divisor = DVS_W'(period);
                            div_init    = DIV_W'(rate_num) << (DIV_W - K_RATE_NUM);
                            div_k       = DCNT_W'(K_RATE_NUM);
                            div_op      = OP_RATE_INST;
                        end
                    end

                    CMD_LOOP_END:
                    begin
                        miss_next = over_budget;
                        if (over_budget && (missed_reg != '1))
                        begin
                            missed_next = missed_reg + MISS_W'(1);
                        end
                        active_next = act_sat ? '1 : act_sum[ACT_W-1:0];
                        budget_next = budget_reg + BUDGET_W'(target_reg);
                        if (window_hit)
                        begin
                            // window closed: form the load from the updated sums
                            count_next = '0;
                            op_next    = OP_LOAD_RATIO;
                            state_next = S_MAC;
                        end
                        else
                        begin
                            count_next = cnt_inc[CNT_W-1:0];
                        end
                    end

                    CMD_TX_START:
                    begin
                        tx_start_next = now_reg;
                    end

                    default:
                    begin
                        // tx done: a pending start is consumed even if unusable
                        if (tx_start_reg != '0)
                        begin
                            tx_start_next = '0;
                            if (latency_ok)
                            begin
                                div_go      = 1'b1;
                                div_divisor = DVS_W'(LAT_SCALE);
                                div_init    = DIV_W'(lat_num) << (DIV_W - K_LAT_NUM);
                                div_k       = DCNT_W'(K_LAT_NUM);
                                div_op      = OP_LAT_INST;
                            end
                        end
                    end
                endcase
            end

            S_DIV:
            begin
                rem_next = div_ge ? div_sub[DVS_W-1:0] : div_trial[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], div_ge};
                cnt_next = cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1))
                begin
                    state_next = S_POST;
                end
            end

            S_POST:
            begin
                case (op_reg)
                    OP_RATE_INST:
                    begin
                        t_next     = rate_inst;
                        op_next    = OP_RATE_EMA;
                        state_next = S_MAC;
                    end
                    OP_RATE_EMA:
                    begin
                        rate_next  = quo_reg[RATE_W-1:0];
                        state_next = S_FINISH;
                    end
                    OP_LOAD_RATIO:
                    begin
                        t_next     = RATE_W'(load_level);
                        op_next    = OP_LOAD_EMA;
                        state_next = S_MAC;
                    end
                    OP_LOAD_EMA:
                    begin
                        load_next  = quo_reg[LOAD_W-1:0];
                        state_next = S_FINISH;
                    end
                    OP_LAT_INST:
                    begin
                        t_next        = lat_inst;
                        delta_next    = lat_delta;
                        prev_lat_next = lat_inst;
                        op_next       = OP_LAT_EMA;
                        state_next    = S_MAC;
                    end
                    OP_LAT_EMA:
                    begin
                        lat_next   = quo_reg[LAT_W-1:0];
                        state_next = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_MAC:
            begin
                state_next = S_FINISH;
                case (op_reg)
                    OP_LOAD_RATIO:
                    begin
                        // sums clear whether or not a load can be formed
                        active_next = '0;
                        budget_next = '0;
                        if (budget_reg != '0)
                        begin
                            div_go      = 1'b1;
                            div_divisor = budget_reg;
                            div_init    = {pct_prod, {FRAC_BITS{1'b0}}};
                            div_k       = DCNT_W'(DIV_W);
                            div_op      = OP_LOAD_RATIO;
                        end
                    end
                    OP_RATE_EMA:
                    begin
                        div_go      = 1'b1;
                        div_divisor = DVS_W'(RATE_DEN);
                        div_init    = DIV_W'(rate_ema_num) << (DIV_W - K_EMA);
                        div_k       = DCNT_W'(K_EMA);
                        div_op      = OP_RATE_EMA;
                    end
                    OP_LOAD_EMA:
                    begin
                        div_go      = 1'b1;
                        div_divisor = DVS_W'(LOAD_DEN);
                        div_init    = DIV_W'(load_ema_num) << (DIV_W - K_LOAD_EMA);
                        div_k       = DCNT_W'(K_LOAD_EMA);
                        div_op      = OP_LOAD_EMA;
                    end
                    OP_LAT_EMA:
                    begin
                        // jitter gain of 1/8 is a plain shift
                        jitter_next = jit_acc[JIT_W+JIT_SHIFT-1:JIT_SHIFT];
                        div_go      = 1'b1;
                        div_divisor = DVS_W'(LAT_DEN);
                        div_init    = DIV_W'(lat_ema_num) << (DIV_W - K_EMA);
                        div_k       = DCNT_W'(K_EMA);
                        div_op      = OP_LAT_EMA;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_FINISH:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_rate_next   = rate_reg;
                    out_load_next   = load_reg;
                    out_lat_next    = lat_reg;
                    out_jit_next    = jitter_reg;
                    out_missed_next = missed_reg;
                    out_miss_next   = miss_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // divider launch: dividend pre-aligned to the top of the shift register
        if (div_go)
        begin
            rem_next     = '0;
            divisor_next = div_divisor;
            quo_next     = div_init;
            cnt_next     = div_k;
            op_next      = div_op;
            state_next   = S_DIV;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_RATE_INST;
            cmd_reg        <= CMD_LOOP_START;
            cnt_reg        <= '0;
            target_reg     <= TARGET_W'(TARGET_RST);
            window_reg     <= WIN_W'(WIN_RST);
            offset_reg     <= OFFS_W'(OFFS_RST);
            min_period_reg <= PERIOD_W'(MINP_RST);
            max_period_reg <= PERIOD_W'(MAXP_RST);
            max_lat_reg    <= PERIOD_W'(MAXLAT_RST);
            loop_start_reg <= '0;
            prev_start_reg <= '0;
            tx_start_reg   <= '0;
            rate_reg       <= RATE_W'(RATE_RST);
            load_reg       <= LOAD_W'(LOAD_RST);
            lat_reg        <= LAT_W'(LAT_RST);
            prev_lat_reg   <= LAT_W'(LAT_RST);
            jitter_reg     <= JIT_W'(JIT_RST);
            missed_reg     <= '0;
            active_reg     <= '0;
            budget_reg     <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            cmd_reg        <= cmd_next;
            cnt_reg        <= cnt_next;
            target_reg     <= target_next;
            window_reg     <= window_next;
            offset_reg     <= offset_next;
            min_period_reg <= min_period_next;
            max_period_reg <= max_period_next;
            max_lat_reg    <= max_lat_next;
            loop_start_reg <= loop_start_next;
            prev_start_reg <= prev_start_next;
            tx_start_reg   <= tx_start_next;
            rate_reg       <= rate_next;
            load_reg       <= load_next;
            lat_reg        <= lat_next;
            prev_lat_reg   <= prev_lat_next;
            jitter_reg     <= jitter_next;
            missed_reg     <= missed_next;
            active_reg     <= active_next;
            budget_reg     <= budget_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // working and payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        diff_reg       <= diff_next;
        miss_reg       <= miss_next;
        t_reg          <= t_next;
        delta_reg      <= delta_next;
        rem_reg        <= rem_next;
        divisor_reg    <= divisor_next;
        quo_reg        <= quo_next;
        out_rate_reg   <= out_rate_next;
        out_load_reg   <= out_load_next;
        out_lat_reg    <= out_lat_next;
        out_jit_reg    <= out_jit_next;
        out_missed_reg <= out_missed_next;
        out_miss_reg   <= out_miss_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an accepted event leaves the block busy in the next cycle
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, events.valid && events.ready, !events.ready, "event accepted while busy")
    // a result only appears from the hand-over state
    `ASSERT_IMPLIES(a_result_from_finish, clk, rst_n, $rose(out_valid_reg), $past(state_reg == S_FINISH), "result raised outside hand-over")
    // a missed deadline flag always comes with a non-zero count
    `ASSERT_IMPLIES(a_miss_counted, clk, rst_n, out_valid_reg && out_miss_reg, out_missed_reg != '0, "missed deadline not counted")
    // divider remainder stays below the divisor
    `ASSERT_IMPLIES(a_rem_bound, clk, rst_n, state_reg == S_DIV, rem_reg < divisor_reg, "divider remainder out of range")
    // smoothed load never passes the 99.9 percent cap
    `ASSERT_ALWAYS(a_load_cap, clk, rst_n, load_reg <= LOAD_W'(LOAD_CAP), "cpu load above cap")

endmodule

// ===== test/rltm_timing_checker.sv =====
// ----------------------------------------------------------------------------
// rltm_timing_checker
// watches the event, result and register channels of the loop timing
// monitor, keeps its own copy of the estimators and compares every result
// request with the figures it predicts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rltm_timing_checker (
    input  logic   clk,
    input  logic   rst_n,
    rltm_event_if  ev,
    rltm_result_if res,
    rltm_cfg_if    cfg,
    output int     failures,
    output int     pending,
    output int     compared
);
    import rltm_pkg::*;

    localparam longint unsigned TIME_MASK  = (64'd1 << TIME_BITS) - 1;
    localparam longint unsigned ACTIVE_TOP = (64'd1 << ACT_W) - 1;
    localparam longint unsigned MISS_TOP   = 64'hFFFF_FFFF;
    localparam longint unsigned RATE_TOP   = 64'd1000 << FRAC_BITS;
    localparam longint unsigned LOAD_TOP   = ((64'd999 << FRAC_BITS) + 5) / 10;
    localparam longint unsigned RATE_NUMER = 64'd1000000 << FRAC_BITS;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [LOAD_W-1:0] load;
        logic [LAT_W-1:0]  latency;
        logic [JIT_W-1:0]  jitter;
        logic [MISS_W-1:0] missed;
        logic              miss_now;
    } figures_t;

    // register copy
    longint unsigned target_us, window_len, offset_q8, min_us, max_us, lat_limit_us;

    // estimator copy
    longint unsigned start_us, prev_start_us, tx_start_us;
    longint unsigned rate_q8, load_q8, lat_q8, prev_lat_q8, jitter_q8, missed_cnt;
    longint unsigned active_acc, budget_acc, sample_cnt;

    figures_t figures_due[$];

    // advance the estimators by one event and return the figures it leaves
    function automatic figures_t track_event(cmd_t kind, longint unsigned ts);
        longint unsigned span, inst, delta, ratio;
        figures_t f;
        f.miss_now = 1'b0;
        case (kind)
            CMD_LOOP_START:
            begin
                start_us = ts;
                if (prev_start_us != 0)
                begin
                    span = (ts - prev_start_us) & TIME_MASK;
                    if (span > min_us && span < max_us && span != 0)
                    begin
                        inst = (RATE_NUMER + span / 2) / span;
                        if (inst > RATE_TOP)
                            inst = RATE_TOP;
                        rate_q8 = (rate_q8 * 19 + inst + 10) / 20;
                    end
                end
                prev_start_us = ts;
            end
            CMD_LOOP_END:
            begin
                span = (ts - start_us) & TIME_MASK;
                f.miss_now = span > target_us;
                if (f.miss_now && missed_cnt < MISS_TOP)
                    missed_cnt++;
                if (span > ACTIVE_TOP - active_acc)
                    active_acc = ACTIVE_TOP;
                else
                    active_acc += span;
                budget_acc += target_us;
                sample_cnt = (sample_cnt + 1) & 64'h1FF;
                if (sample_cnt >= window_len)
                begin
                    if (budget_acc > 0)
                    begin
                        ratio = ((active_acc * 100) << FRAC_BITS) / budget_acc;
                        if (ratio > LOAD_TOP)
                            ratio = LOAD_TOP;
                        ratio += offset_q8;
                        if (ratio > LOAD_TOP)
                            ratio = LOAD_TOP;
                        load_q8 = (load_q8 * 7 + ratio * 3 + 5) / 10;
                    end
                    active_acc = 0;
                    budget_acc = 0;
                    sample_cnt = 0;
                end
            end
            CMD_TX_START:
                tx_start_us = ts;
            default:
            begin
                // a pending start is used up even when the duration is rejected
                if (tx_start_us != 0)
                begin
                    span = (ts - tx_start_us) & TIME_MASK;
                    tx_start_us = 0;
                    if (span != 0 && span < lat_limit_us)
                    begin
                        inst = ((span << FRAC_BITS) + 500) / 1000;
                        delta = inst > prev_lat_q8 ? inst - prev_lat_q8 : prev_lat_q8 - inst;
                        prev_lat_q8 = inst;
                        jitter_q8 = (jitter_q8 * 7 + delta + 4) >> 3;
                        lat_q8 = (lat_q8 * 17 + inst * 3 + 10) / 20;
                    end
                end
            end
        endcase
        f.rate    = RATE_W'(rate_q8);
        f.load    = LOAD_W'(load_q8);
        f.latency = LAT_W'(lat_q8);
        f.jitter  = JIT_W'(jitter_q8);
        f.missed  = MISS_W'(missed_cnt);
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        figures_t got, want;
        if (!rst_n)
        begin
            target_us     = 10000;
            window_len    = 50;
            offset_q8     = (64'd9 << FRAC_BITS) / 2;
            min_us        = 1000;
            max_us        = 100000;
            lat_limit_us  = 100000;
            start_us      = 0;
            prev_start_us = 0;
            tx_start_us   = 0;
            rate_q8       = 64'd100 << FRAC_BITS;
            load_q8       = 64'd5 << FRAC_BITS;
            lat_q8        = ((64'd12 << FRAC_BITS) + 5) / 10;
            prev_lat_q8   = lat_q8;
            jitter_q8     = ((64'd2 << FRAC_BITS) + 5) / 10;
            missed_cnt    = 0;
            active_acc    = 0;
            budget_acc    = 0;
            sample_cnt    = 0;
            figures_due.delete();
            failures = 0;
            compared = 0;
            pending <= 0;
        end
        else
        begin
            // results first: a result never belongs to an event taken at the same edge
            if (res.valid && res.ready)
            begin
                got = {res.control_rate_q8, res.cpu_load_q8, res.latency_q8, res.jitter_q8,
                       res.missed_deadlines, res.deadline_missed_now};
                if (figures_due.size() == 0)
                begin
                    if (failures < 10)
                        $display("%0t: result request with nothing expected: rate %0d load %0d",
                                 $realtime, got.rate, got.load);
                    failures++;
                end
                else
                begin
                    want = figures_due.pop_front();
                    compared++;
                    if (got !== want)
                    begin
                        if (failures < 10)
                        begin
                            $write("%0t: result %0d (expected/actual) rate %0d/%0d load %0d/%0d",
                                   $realtime, compared, want.rate, got.rate,
                                   want.load, got.load);
                            $display(" latency %0d/%0d jitter %0d/%0d missed %0d/%0d now %0b/%0b",
                                     want.latency, got.latency, want.jitter, got.jitter,
                                     want.missed, got.missed, want.miss_now, got.miss_now);
                        end
                        failures++;
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_TARGET_PERIOD: target_us    = 64'(cfg.data[TARGET_W-1:0]);
                    REG_WINDOW:        window_len   = 64'(cfg.data[WIN_W-1:0]);
                    REG_LOAD_OFFSET:   offset_q8    = 64'(cfg.data[OFFS_W-1:0]);
                    REG_MIN_PERIOD:    min_us       = 64'(cfg.data);
                    REG_MAX_PERIOD:    max_us       = 64'(cfg.data);
                    REG_MAX_LATENCY:   lat_limit_us = 64'(cfg.data);
                    default: ;
                endcase
            end
            if (ev.valid && ev.ready)
                figures_due.push_back(track_event(cmd_t'(ev.command), 64'(ev.timestamp_us)));
            pending <= figures_due.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives timestamped loop and transmit events into the timing monitor, moves
// the registers through several settings and lets the checker compare every
// result request against its own estimator copy
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import rltm_pkg::*;

    // run shape
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 325;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_EVERY  = 700;
    localparam int TAIL_CYCLES = 120;

    // index with no register behind it, written to show it is ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam logic [TIME_BITS-1:0] TS_TOP    = {TIME_BITS{1'b1}};

    logic clk;
    logic rst_n;

    rltm_event_if  ev();
    rltm_result_if res();
    rltm_cfg_if    cfg();

    int fail_count;
    int pending_count;
    int compared_count;

    // sender bookkeeping
    int events_sent;
    int burst_left;
    bit steady;
    int cycle_count;

    realtime_loop_timing_monitor_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (ev),
        .results (res),
        .cfg     (cfg)
    );

    rltm_timing_checker u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev       (ev),
        .res      (res),
        .cfg      (cfg),
        .failures (fail_count),
        .pending  (pending_count),
        .compared (compared_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // reset once, at the start of the run
    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // offer one event request; bursts of random length with random gaps
    // between them, unless the phase runs with no idling at all
    task automatic send_event(input cmd_t kind, input logic [TIME_BITS-1:0] ts);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                ev.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        ev.valid        <= 1'b1;
        ev.command      <= kind;
        ev.timestamp_us <= ts;
        do
            @(posedge clk);
        while (!ev.ready);
        events_sent++;
    endtask

    // one register write request; valid stays up across back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
    endtask

    task automatic program_regs(input int unsigned tgt, input int unsigned win,
                                input int unsigned offs, input int unsigned minp,
                                input int unsigned maxp, input int unsigned maxlat);
        write_reg(REG_TARGET_PERIOD, CFG_DATA_W'(tgt));
        write_reg(REG_WINDOW, CFG_DATA_W'(win));
        write_reg(REG_LOAD_OFFSET, CFG_DATA_W'(offs));
        write_reg(REG_MIN_PERIOD, CFG_DATA_W'(minp));
        write_reg(REG_MAX_PERIOD, CFG_DATA_W'(maxp));
        write_reg(REG_MAX_LATENCY, CFG_DATA_W'(maxlat));
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        cfg.valid <= 1'b0;
    endtask

    // stop offering and wait for every expected result to come back, so the
    // block is idle before the next register writes
    task automatic drain_results();
        ev.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // result side: stall pattern of its own, plus a long hold-off every so
    // often while the sender keeps offering, so the block backs up
    initial
    begin : result_drain
        int hold_left;
        int next_hold;
        int mode;
        int mode_left;
        int tick;
        hold_left = 0;
        next_hold = HOLD_EVERY;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        res.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_left == 0 && events_sent >= next_hold)
            begin
                hold_left = HOLD_CYCLES;
                next_hold += HOLD_EVERY;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: res.ready <= 1'b1;
                    1: res.ready <= 1'($urandom_range(0, 1));
                    2: res.ready <= ($urandom_range(0, 3) == 0);
                    default: res.ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned tgt, win, offs, minp, maxp, maxlat;
        int unsigned period, active, lat;
        int          phase;
        int          phase_base;
        int          settings;
        int          directed;
        int          pick;
        logic [TIME_BITS-1:0] clock_us;
        logic [TIME_BITS-1:0] tx_at;
        logic [TIME_BITS-1:0] ts;

        events_sent = 0;
        burst_left  = 0;
        steady      = 1'b0;
        settings    = 1;
        ev.valid        <= 1'b0;
        ev.command      <= CMD_LOOP_START;
        ev.timestamp_us <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= REG_TARGET_PERIOD;
        cfg.data  <= '0;

        wait (rst_n === 1'b1);
        @(posedge clk);

        // ---- directed part, registers at their reset values ----
        // loop end before any loop start, measured from time zero
        send_event(CMD_LOOP_END, 48'd5000);
        // tx done with nothing pending
        send_event(CMD_TX_DONE, 48'd1234);
        // a tx start at time zero counts as no start
        send_event(CMD_TX_START, 48'd0);
        send_event(CMD_TX_DONE, 48'd700);
        // loop start at time zero leaves no previous start behind
        send_event(CMD_LOOP_START, 48'd0);
        send_event(CMD_LOOP_START, 48'd10000);
        send_event(CMD_LOOP_START, 48'd20000);
        // loop over budget
        send_event(CMD_LOOP_END, 48'd35000);
        // transmit duration across the timestamp wrap
        send_event(CMD_TX_START, TS_TOP - 48'd99);
        send_event(CMD_TX_DONE, 48'd900);
        // zero duration, then one above the latency limit
        send_event(CMD_TX_START, 48'd50);
        send_event(CMD_TX_DONE, 48'd50);
        send_event(CMD_TX_START, 48'd100);
        send_event(CMD_TX_DONE, 48'd200100);
        // period across the wrap, below the period window
        send_event(CMD_LOOP_START, TS_TOP);
        send_event(CMD_LOOP_START, 48'd499);
        // huge active time saturates the active sum
        send_event(CMD_LOOP_END, TS_TOP - 48'd1);
        drain_results();

        // zero budget, zero window, zero latency limit, widest period window
        program_regs(0, 0, 25600, 0, 1000000, 0);
        settings++;
        send_event(CMD_LOOP_START, 48'd1000);
        // one microsecond period, instant rate capped at 1000 Hz
        send_event(CMD_LOOP_START, 48'd1001);
        send_event(CMD_LOOP_END, 48'd1001);
        send_event(CMD_TX_START, 48'd5);
        send_event(CMD_TX_DONE, 48'd10);
        drain_results();

        // largest budget, single-sample window, empty period window
        program_regs(100000, 1, 0, 5000, 5000, 1000000);
        settings++;
        send_event(CMD_LOOP_START, 48'd6000);
        send_event(CMD_LOOP_END, 48'd106001);
        send_event(CMD_TX_START, 48'd1);
        send_event(CMD_TX_DONE, 48'd1000000);
        drain_results();
        directed = events_sent;

        // ---- random part: well-formed loops with some noise ----
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    tgt = 100000; win = 255; offs = 25600;
                    minp = 1; maxp = 1000000; maxlat = 1000000;
                end
                1:
                begin
                    tgt = 1; win = 1; offs = 0;
                    minp = 1; maxp = 3; maxlat = 2;
                end
                default:
                begin
                    tgt  = $urandom_range(1, 100000);
                    win  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
                    offs = $urandom_range(0, 25600);
                    minp = $urandom_range(1, 20000);
                    maxp = ($urandom_range(0, 7) == 0) ? minp : minp + $urandom_range(1, 150000);
                    maxlat = $urandom_range(1000, 1000000);
                end
            endcase
            program_regs(tgt, win, offs, minp, maxp, maxlat);
            settings++;

            // one phase runs with no sender idling at all
            steady = (phase == 3);
            clock_us = ($urandom_range(0, 2) == 0)
                       ? TS_TOP - TIME_BITS'($urandom_range(0, 3000000))
                       : TIME_BITS'({$urandom, $urandom});
            phase_base = events_sent;

            while (events_sent - phase_base < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 8)
                begin
                    // period near the window edges, around the rate cap or inside
                    case ($urandom_range(0, 7))
                        0: period = minp;
                        1: period = minp + 1;
                        2: period = maxp - 1;
                        3: period = maxp;
                        4: period = $urandom_range(1, 1200);
                        default: period = $urandom_range(minp, maxp);
                    endcase
                    // active time around the budget
                    case ($urandom_range(0, 5))
                        0: active = tgt;
                        1: active = tgt + 1;
                        2: active = 0;
                        default: active = $urandom_range(0, 2 * tgt);
                    endcase
                    send_event(CMD_LOOP_START, clock_us);
                    if ($urandom_range(0, 1) == 1)
                    begin
                        case ($urandom_range(0, 5))
                            0: lat = maxlat - 1;
                            1: lat = maxlat;
                            2: lat = 0;
                            default: lat = $urandom_range(1, maxlat);
                        endcase
                        tx_at = clock_us + TIME_BITS'(active / 2);
                        send_event(CMD_TX_START, tx_at);
                        send_event(CMD_TX_DONE, tx_at + TIME_BITS'(lat));
                    end
                    send_event(CMD_LOOP_END, clock_us + TIME_BITS'(active));
                    clock_us = clock_us + TIME_BITS'(period);
                end
                else
                begin
                    // noise: any event kind, any time or a time near the loop clock
                    ts = ($urandom_range(0, 1) == 1)
                         ? TIME_BITS'({$urandom, $urandom})
                         : clock_us + TIME_BITS'($urandom_range(0, 50000));
                    send_event(cmd_t'($urandom_range(0, 3)), ts);
                end
            end
            drain_results();
        end
        steady = 1'b0;

        // let any stray result request show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d event requests (%0d directed) over %0d register settings",
                 events_sent, directed, settings);
        $display("%0d result requests compared, %0d mismatches", compared_count, fail_count);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
